// ----- src/lsh3_pkg.sv -----
package lsh3_pkg;

  // pixel and register field widths
  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;
  localparam int GAIN_W     = 10;
  localparam int KROW_W     = 18;
  localparam int COEF_W     = 6;
  localparam int KSIZE      = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 18;

  // kernel sum and scaled result widths
  localparam int SUM_W  = 18;
  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int VAL_W  = 29;

  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_MAX    = 255;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_Q8       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_TOP    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_MID    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_BOTTOM = 3'd5;

  typedef logic [PIX_W-1:0] pix_t;

  // one line store word: previous row in the low byte, the row before in the high byte
  typedef struct packed {
    pix_t older;
    pix_t recent;
  } line_word_t;

endpackage

// ----- src/laplacian_sharpen_3x3.sv -----
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: pixel_in; tuser: mode
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: pixel_out; tlast: run_last;
//           |     |                               | tuser: frame_last
// cfg       | in  | cfg_valid_i / cfg_ready_o     | cfg_addr_i: register, cfg_data_i: value
//
// one item is in flight at a time; a row zero pixel or an ignored beat is taken in idle,
// a first-column item with no result passes through the line store read only, and an item
// with a result goes through line store read, kernel sum, gain multiply and output load, with a
// second sum/multiply/load pass for the right edge column
// the line store is one memory holding both previous rows; it has no clearing pass
// after reset, since entries are always written in a frame before they are read
// a stalled output holds the block in its output load step; input waits meanwhile
module laplacian_sharpen_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] pixel_in
  input  logic                              s_axis_tuser,  // [0] mode
  // master side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [7:0] pixel_out
  output logic                              m_axis_tlast,
  output logic                              m_axis_tuser,  // [0] frame_last
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lsh3_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [lsh3_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = (AW + 1 > lsh3_pkg::WIDTH_W) ? AW + 1 : lsh3_pkg::WIDTH_W;
  localparam int LW_W  = 2 * lsh3_pkg::PIX_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PUSH = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_GAIN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  // configuration registers
  logic [lsh3_pkg::WIDTH_W-1:0]         width_q;
  logic [lsh3_pkg::HEIGHT_W-1:0]        height_q;
  logic signed [lsh3_pkg::GAIN_W-1:0]   gain_q;
  logic [lsh3_pkg::KROW_W-1:0]          kern_q [lsh3_pkg::KSIZE];

  // frame position
  logic [AW-1:0]                col_q;
  logic [lsh3_pkg::ROW_W-1:0]   row_q;
  logic [AW-1:0]                dcol_q;
  logic                         drain_q;

  // item in flight
  logic [2:0]                   state_q;
  logic [AW-1:0]                item_c_q;
  lsh3_pkg::pix_t               item_pix_q;
  logic                         item_drain_q;
  logic                         item_top_b_q;
  logic                         pend_q;
  logic                         rl_q;
  logic                         fl_q;

  // window, [column oldest..newest][row top..bottom]
  lsh3_pkg::pix_t               win_q [lsh3_pkg::KSIZE][lsh3_pkg::KSIZE];

  // arithmetic stages
  logic signed [lsh3_pkg::SUM_W-1:0]  sum_d, sum_q;
  logic signed [lsh3_pkg::VAL_W-1:0]  val_d, val_q;
  lsh3_pkg::pix_t                     clamp_pix;

  // output register
  logic                         out_valid_q;
  lsh3_pkg::pix_t               out_pix_q;
  logic                         out_last_q;
  logic                         out_flast_q;

  // line store port signals
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  lsh3_pkg::line_word_t         ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [LW_W-1:0]              ram_rdata;
  lsh3_pkg::line_word_t         rd_word;

  logic [AW-1:0]                w_last;
  logic [lsh3_pkg::ROW_W-1:0]   h_last;
  logic [CMP_W-1:0]             width_ext;
  logic                         s_fire;
  logic                         cfg_fire;
  logic                         geom_wr;
  logic                         pix_go;
  logic                         drn_go;
  logic                         out_free;
  logic                         need_first;
  logic                         need_second;
  lsh3_pkg::pix_t               new_top;
  lsh3_pkg::pix_t               new_mid;
  lsh3_pkg::pix_t               new_bot;

  // effective geometry, clamped to the legal range
  assign width_ext = CMP_W'(width_q);

  always_comb begin
    if (width_q == '0) begin
      w_last = '0;
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      w_last = AW'(MAX_WIDTH - 1);
    end else begin
      w_last = AW'(width_q - lsh3_pkg::WIDTH_W'(1));
    end
  end

  always_comb begin
    if (height_q == '0) begin
      h_last = '0;
    end else if (height_q > lsh3_pkg::HEIGHT_W'(lsh3_pkg::MAX_HEIGHT)) begin
      h_last = lsh3_pkg::ROW_W'(lsh3_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = lsh3_pkg::ROW_W'(height_q - lsh3_pkg::HEIGHT_W'(1));
    end
  end

  // handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i && cfg_ready_o;
  assign geom_wr       = cfg_fire && ((cfg_addr_i == lsh3_pkg::REG_IMAGE_WIDTH) ||
                                      (cfg_addr_i == lsh3_pkg::REG_IMAGE_HEIGHT));
  assign out_free      = !out_valid_q || m_axis_tready;

  assign pix_go = s_fire && !s_axis_tuser && !drain_q && !(col_q > w_last);
  assign drn_go = s_fire && s_axis_tuser && drain_q && !(dcol_q > w_last);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 11'd1024;
      height_q  <= 13'd1024;
      gain_q    <= -10'sd256;
      kern_q[0] <= 18'd64;
      kern_q[1] <= 18'd7937;
      kern_q[2] <= 18'd64;
    end else if (cfg_fire) begin
      unique case (cfg_addr_i)
        lsh3_pkg::REG_IMAGE_WIDTH:   width_q   <= cfg_data_i[lsh3_pkg::WIDTH_W-1:0];
        lsh3_pkg::REG_IMAGE_HEIGHT:  height_q  <= cfg_data_i[lsh3_pkg::HEIGHT_W-1:0];
        lsh3_pkg::REG_GAIN_Q8:       gain_q    <= $signed(cfg_data_i[lsh3_pkg::GAIN_W-1:0]);
        lsh3_pkg::REG_KERNEL_TOP:    kern_q[0] <= cfg_data_i;
        lsh3_pkg::REG_KERNEL_MID:    kern_q[1] <= cfg_data_i;
        lsh3_pkg::REG_KERNEL_BOTTOM: kern_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame position counters, restarted by a geometry write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      dcol_q  <= '0;
      drain_q <= 1'b0;
    end else begin
      priority if (geom_wr) begin
        col_q   <= '0;
        row_q   <= '0;
        dcol_q  <= '0;
        drain_q <= 1'b0;
      end else if (pix_go) begin
        if (col_q == w_last) begin
          col_q <= '0;
          if (row_q == h_last) begin
            drain_q <= 1'b1;
          end else begin
            row_q <= row_q + lsh3_pkg::ROW_W'(1);
          end
        end else begin
          col_q <= col_q + AW'(1);
        end
      end else if (drn_go) begin
        if (dcol_q == w_last) begin
          col_q   <= '0;
          row_q   <= '0;
          dcol_q  <= '0;
          drain_q <= 1'b0;
        end else begin
          dcol_q <= dcol_q + AW'(1);
        end
      end else begin
        // no beat taken, position holds
      end
    end
  end

  // line store access: row zero writes directly, later rows read then write back
  assign rd_word   = lsh3_pkg::line_word_t'(ram_rdata);
  assign ram_re    = (pix_go && (row_q != '0)) || drn_go;
  assign ram_raddr = s_axis_tuser ? dcol_q : col_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = col_q;
    ram_wdata = '{older: '0, recent: s_axis_tdata};
    if (pix_go && (row_q == '0)) begin
      ram_we = 1'b1;
    end else if ((state_q == ST_PUSH) && !item_drain_q) begin
      ram_we    = 1'b1;
      ram_waddr = item_c_q;
      ram_wdata = '{older: rd_word.recent, recent: item_pix_q};
    end
  end

  lsh3_ram #(
    .WIDTH (LW_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // new window column from the line store word
  assign new_mid     = rd_word.recent;
  assign new_top     = item_top_b_q ? rd_word.older : new_mid;
  assign new_bot     = item_drain_q ? new_mid : item_pix_q;
  assign need_first  = (item_c_q != '0);
  assign need_second = (item_c_q == w_last);

  // kernel sum over the window
  always_comb begin
    logic signed [lsh3_pkg::SUM_W-1:0]  acc;
    logic signed [lsh3_pkg::COEF_W-1:0] k;
    logic signed [lsh3_pkg::PROD_W-1:0] prod;
    acc = '0;
    for (int x = 0; x < lsh3_pkg::KSIZE; x++) begin
      for (int y = 0; y < lsh3_pkg::KSIZE; y++) begin
        k    = $signed(kern_q[x][lsh3_pkg::COEF_W*y +: lsh3_pkg::COEF_W]);
        prod = k * $signed({1'b0, win_q[y][x]});
        acc  = acc + lsh3_pkg::SUM_W'(prod);
      end
    end
    sum_d = acc;
  end

  // centre pixel plus scaled kernel sum, all in Q8
  always_comb begin
    logic signed [lsh3_pkg::GAIN_W+lsh3_pkg::SUM_W-1:0] gprod;
    gprod = gain_q * sum_q;
    val_d = lsh3_pkg::VAL_W'(gprod) + $signed({13'b0, win_q[1][1], 8'b0});
  end

  // clamp to the pixel range, then drop the fraction
  always_comb begin
    if (val_q[lsh3_pkg::VAL_W-1]) begin
      clamp_pix = '0;
    end else if (val_q > lsh3_pkg::VAL_W'(lsh3_pkg::PIX_MAX * 256)) begin
      clamp_pix = lsh3_pkg::pix_t'(lsh3_pkg::PIX_MAX);
    end else begin
      clamp_pix = val_q[15:8];
    end
  end

  // item sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      item_c_q     <= '0;
      item_pix_q   <= '0;
      item_drain_q <= 1'b0;
      item_top_b_q <= 1'b0;
      pend_q       <= 1'b0;
      rl_q         <= 1'b0;
      fl_q         <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pix_go && (row_q != '0)) begin
            item_c_q     <= col_q;
            item_pix_q   <= s_axis_tdata;
            item_drain_q <= 1'b0;
            item_top_b_q <= (row_q[lsh3_pkg::ROW_W-1:1] != '0);
            state_q      <= ST_PUSH;
          end else if (drn_go) begin
            item_c_q     <= dcol_q;
            item_pix_q   <= s_axis_tdata;
            item_drain_q <= 1'b1;
            item_top_b_q <= (h_last != '0);
            state_q      <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          pend_q <= need_first && need_second;
          rl_q   <= !(need_first && need_second);
          fl_q   <= !need_first && need_second && item_drain_q;
          state_q <= (need_first || need_second) ? ST_SUM : ST_IDLE;
        end
        ST_SUM: begin
          state_q <= ST_GAIN;
        end
        ST_GAIN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (pend_q) begin
              pend_q  <= 1'b0;
              rl_q    <= 1'b1;
              fl_q    <= item_drain_q;
              state_q <= ST_SUM;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // window update: column push on entry, right edge shift before the second result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < lsh3_pkg::KSIZE; c++) begin
        for (int r = 0; r < lsh3_pkg::KSIZE; r++) begin
          win_q[c][r] <= '0;
        end
      end
    end else if (state_q == ST_PUSH) begin
      if (need_first) begin
        win_q[0] <= win_q[1];
        win_q[1] <= win_q[2];
      end else begin
        win_q[0] <= '{new_top, new_mid, new_bot};
        win_q[1] <= '{new_top, new_mid, new_bot};
      end
      win_q[2] <= '{new_top, new_mid, new_bot};
    end else if ((state_q == ST_EMIT) && out_free && pend_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
    end
  end

  // arithmetic stage registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      sum_q <= sum_d;
    end
    if (state_q == ST_GAIN) begin
      val_q <= val_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_EMIT) && out_free) begin
      out_pix_q   <= clamp_pix;
      out_last_q  <= rl_q;
      out_flast_q <= fl_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_flast_q;

endmodule

// ----- src/lsh3_ram.sv -----
module lsh3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lsh3_chk.sv -----
module lsh3_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  // the frame's final pixel always closes its input's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame_last without run_last");

  // a result is loaded only while the input side is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while input was open");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
       $stable(m_axis_tuser)))
    else $error("stalled output beat changed");

  // the configuration port never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write stalled");

endmodule

bind laplacian_sharpen_3x3 lsh3_chk u_lsh3_chk (.*);

// ----- verif/sharpen_checker.sv -----
`timescale 1ns / 100ps

// watches the pixel, result and register channels, predicts every sharpened
// pixel from its own copy of the line stores and window, and compares
module sharpen_checker
  import lsh3_pkg::*;
#(
  parameter int   MAX_WIDTH  = 1024,
  parameter logic MODE_DRAIN = 1'b1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel input channel
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [7:0]            s_tdata_i,   // [7:0] pixel_in
  input  logic                  s_tuser_i,   // [0] mode
  // result channel
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [7:0]            m_tdata_i,   // [7:0] pixel_out
  input  logic                  m_tlast_i,
  input  logic                  m_tuser_i,   // [0] frame_last
  // register writes
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    frames_o
);

  localparam int SHOWN_MISMATCHES = 40;

  typedef struct packed {
    pix_t pixel;
    logic run_last;
    logic frame_last;
  } sharp_res_t;

  // register copies
  logic [WIDTH_W-1:0]       width_q;
  logic [HEIGHT_W-1:0]      height_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic [KROW_W-1:0]        krow_q [KSIZE];

  // row just above and the row before it
  pix_t prev_row  [MAX_WIDTH];
  pix_t older_row [MAX_WIDTH];
  // window indexed [column oldest..newest][row top..bottom]
  logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] win_q;
  int unsigned row_q, col_q, drain_q;
  bit          draining_q;

  sharp_res_t due_pixels [$];
  int         errors, results, frames;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_q;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_q;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int coef(int r, int c);
    logic signed [COEF_W-1:0] k;
    k = krow_q[r][COEF_W*c +: COEF_W];
    return int'(k);
  endfunction

  // centre pixel plus gain times kernel sum, clamped, then floored
  function automatic pix_t sharpen_at_window();
    longint acc, v;
    acc = 0;
    for (int r = 0; r < KSIZE; r++)
      for (int c = 0; c < KSIZE; c++)
        acc += longint'(coef(r, c)) * longint'(win_q[c][r]);
    v = longint'(win_q[1][1]) * 256 + longint'(gain_q) * acc;
    if (v < 0) v = 0;
    if (v > PIX_MAX * 256) v = PIX_MAX * 256;
    return pix_t'(v >> 8);
  endfunction

  function automatic void shift_window();
    win_q[0] = win_q[1];
    win_q[1] = win_q[2];
  endfunction

  // new column enters on the right; column zero replicates left
  function automatic void load_column(int unsigned c, pix_t top, pix_t mid, pix_t bot);
    if (c != 0) shift_window();
    win_q[2] = {bot, mid, top};
    if (c == 0) begin
      win_q[0] = win_q[2];
      win_q[1] = win_q[2];
    end
  endfunction

  // lagging result, plus the right edge result on the last column
  function automatic void emit_column(int unsigned c, int unsigned w, bit last_row);
    sharp_res_t res [2];
    int n;
    n = 0;
    if (c >= 1) begin
      res[0] = '{sharpen_at_window(), 1'b0, 1'b0};
      n = 1;
    end
    if (c == w - 1) begin
      if (c >= 1) shift_window();
      res[n] = '{sharpen_at_window(), 1'b0, last_row};
      n++;
    end
    if (n > 0) res[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) due_pixels.push_back(res[i]);
  endfunction

  function automatic void restart_frame();
    row_q      = 0;
    col_q      = 0;
    drain_q    = 0;
    draining_q = 1'b0;
  endfunction

  function automatic void write_register(logic [CFG_ADDR_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_q = d[WIDTH_W-1:0];
        restart_frame();
      end
      REG_IMAGE_HEIGHT: begin
        height_q = d[HEIGHT_W-1:0];
        restart_frame();
      end
      REG_GAIN_Q8:       gain_q    = d[GAIN_W-1:0];
      REG_KERNEL_TOP:    krow_q[0] = d[KROW_W-1:0];
      REG_KERNEL_MID:    krow_q[1] = d[KROW_W-1:0];
      REG_KERNEL_BOTTOM: krow_q[2] = d[KROW_W-1:0];
      default: ;
    endcase
  endfunction

  // one accepted input beat: frame pixel or drain tick
  function automatic void take_beat(logic mode, pix_t p);
    int unsigned w, h, c, d;
    pix_t mid, top;
    w = eff_width();
    h = eff_height();
    if (mode != MODE_DRAIN) begin
      c = col_q;
      if (draining_q || c >= w) return;
      if (row_q == 0) begin
        prev_row[c] = p;
      end else begin
        mid = prev_row[c];
        top = (row_q >= 2) ? older_row[c] : mid;
        older_row[c] = mid;
        prev_row[c]  = p;
        load_column(c, top, mid, p);
        emit_column(c, w, 1'b0);
      end
      if (c == w - 1) begin
        col_q = 0;
        row_q++;
        if (row_q >= h) draining_q = 1'b1;
      end else begin
        col_q = c + 1;
      end
    end else begin
      if (!draining_q || drain_q >= w) return;
      d   = drain_q;
      mid = prev_row[d];
      top = (h >= 2) ? older_row[d] : mid;
      load_column(d, top, mid, mid);
      emit_column(d, w, 1'b1);
      if (d == w - 1) restart_frame();
      else drain_q = d + 1;
    end
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= SHOWN_MISMATCHES) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic check_result();
    sharp_res_t want;
    if (due_pixels.size() == 0) begin
      report_mismatch($sformatf("result beat %0d arrived with nothing due", results));
      return;
    end
    want = due_pixels.pop_front();
    if (m_tdata_i !== want.pixel)
      report_mismatch($sformatf("result %0d pixel_out %0d, expected %0d",
                                results, m_tdata_i, want.pixel));
    if (m_tlast_i !== want.run_last)
      report_mismatch($sformatf("result %0d run_last %b, expected %b",
                                results, m_tlast_i, want.run_last));
    if (m_tuser_i !== want.frame_last)
      report_mismatch($sformatf("result %0d frame_last %b, expected %b",
                                results, m_tuser_i, want.frame_last));
    if (want.frame_last) frames++;
    results++;
  endtask

  // sample all channels at the edge where beats are taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = 11'd1024;
      height_q = 13'd1024;
      gain_q   = -10'sd256;
      krow_q[0] = 18'd64;
      krow_q[1] = 18'd7937;
      krow_q[2] = 18'd64;
      win_q    = '0;
      restart_frame();
      due_pixels.delete();
      errors   = 0;
      results  = 0;
      frames   = 0;
      errors_o  <= 0;
      pending_o <= 0;
      results_o <= 0;
      frames_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_addr_i, cfg_data_i);
      if (m_tvalid_i && m_tready_i) check_result();
      if (s_tvalid_i && s_tready_i) take_beat(s_tuser_i, s_tdata_i);
      errors_o  <= errors;
      pending_o <= due_pixels.size();
      results_o <= results;
      frames_o  <= frames;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import lsh3_pkg::*;

  localparam int   MAX_WIDTH     = 1024;
  localparam logic MODE_PIXEL    = 1'b0;
  localparam logic MODE_DRAIN    = 1'b1;
  localparam int   SETTLE_CYCLES = 16;
  localparam int   RANDOM_BEATS  = 950;
  // ~1100 beats, each with its busy time, output stalls and an input gap
  localparam longint CYCLE_LIMIT = 600000;

  // kernel rows: four- and eight-neighbor laplacians and coefficient extremes
  localparam logic [KROW_W-1:0] LAP4_EDGE = 18'd64;
  localparam logic [KROW_W-1:0] LAP4_MID  = 18'd7937;
  localparam logic [KROW_W-1:0] LAP8_EDGE = 18'h3FFFF;
  localparam logic [KROW_W-1:0] LAP8_MID  = 18'h3F23F;
  localparam logic [KROW_W-1:0] K_ALL_MIN = 18'h20820;
  localparam logic [KROW_W-1:0] K_ALL_MAX = 18'h1F7DF;
  localparam logic [KROW_W-1:0] K_ZERO    = 18'h00000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [7:0] pixel_in
  logic       s_axis_tuser  = 1'b0; // [0] mode
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [7:0] pixel_out
  logic       m_axis_tlast;
  logic       m_axis_tuser;         // [0] frame_last

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit     calm = 1'b1;
  int     stall_left;
  longint cycles;
  int     beats_sent, ignored_beats;
  int     errors, pending, results, frames;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  laplacian_sharpen_3x3 #(
    .MAX_WIDTH(MAX_WIDTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_addr_i   (cfg_addr),
    .cfg_data_i   (cfg_data)
  );

  sharpen_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MODE_DRAIN(MODE_DRAIN)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tlast_i  (m_axis_tlast),
    .m_tuser_i  (m_axis_tuser),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_addr_i (cfg_addr),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results),
    .frames_o   (frames)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp_dim(int v, int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  function automatic pix_t pick_pixel(int pat);
    case (pat)
      0: return pix_t'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      2: return pix_t'($urandom_range(112, 143));
      default: begin
        case ($urandom_range(0, 3))
          0: return 8'h00;
          1: return 8'hFF;
          default: return pix_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // result side backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left = idle_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("tb_top: errors");
      $finish;
    end
  end

  // one input beat, valid kept high afterwards for back-to-back beats
  task automatic send_beat(logic mode, pix_t pix);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // wait until every due result is out and the block has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // unused upper data bits get junk half of the time
  task automatic set_geometry(int wv, int hv);
    logic [CFG_DATA_W-1:0] dw, dh;
    settle();
    dw = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
    dh = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
    dw[WIDTH_W-1:0]  = WIDTH_W'(wv);
    dh[HEIGHT_W-1:0] = HEIGHT_W'(hv);
    cfg_write(REG_IMAGE_WIDTH, dw);
    cfg_write(REG_IMAGE_HEIGHT, dh);
  endtask

  task automatic set_filter(int gain, logic [KROW_W-1:0] kt, logic [KROW_W-1:0] km,
                            logic [KROW_W-1:0] kb);
    logic [CFG_DATA_W-1:0] dg;
    settle();
    dg = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
    dg[GAIN_W-1:0] = GAIN_W'(gain);
    cfg_write(REG_GAIN_Q8, dg);
    cfg_write(REG_KERNEL_TOP, kt);
    cfg_write(REG_KERNEL_MID, km);
    cfg_write(REG_KERNEL_BOTTOM, kb);
  endtask

  task automatic random_filter();
    logic [KROW_W-1:0] kt, km, kb;
    int g;
    case ($urandom_range(0, 4))
      0: begin kt = LAP4_EDGE; km = LAP4_MID; kb = LAP4_EDGE; end
      1: begin kt = LAP8_EDGE; km = LAP8_MID; kb = LAP8_EDGE; end
      2: begin
        case ($urandom_range(0, 3))
          0: kt = K_ALL_MIN;
          1: kt = K_ALL_MAX;
          2: kt = K_ZERO;
          default: kt = LAP8_EDGE;
        endcase
        km = kt;
        kb = kt;
      end
      default: begin
        kt = KROW_W'($urandom);
        km = KROW_W'($urandom);
        kb = KROW_W'($urandom);
      end
    endcase
    case ($urandom_range(0, 3))
      0: g = int'($urandom_range(0, 1023)) - 512;
      1: g = ($urandom_range(0, 1) != 0) ? -512 : 511;
      2: g = -256;
      default: g = int'($urandom_range(0, 96)) - 48;
    endcase
    set_filter(g, kt, km, kb);
  endtask

  // one frame in raster order, then its drain ticks; a cut frame stops early
  task automatic run_frame(int w, int h, int cut, int pat);
    int total;
    total = w * h;
    for (int i = 0; i < total; i++) begin
      if (i == cut) return;
      if (!calm && $urandom_range(0, 99) < 3) begin
        send_beat(MODE_DRAIN, pix_t'($urandom));  // drain ahead of frame end
        ignored_beats++;
      end
      send_beat(MODE_PIXEL, pick_pixel(pat));
      beats_sent++;
    end
    for (int d = 0; d < w; d++) begin
      if ($urandom_range(0, 99) < 4) begin
        send_beat(MODE_PIXEL, pix_t'($urandom));  // pixel while draining
        ignored_beats++;
      end
      send_beat(MODE_DRAIN, pix_t'($urandom));
      beats_sent++;
    end
    if ($urandom_range(0, 99) < 10) begin
      send_beat(MODE_DRAIN, pix_t'($urandom));    // drain after the frame restarted
      ignored_beats++;
    end
  endtask

  initial begin
    pix_t corner_px [6];
    int   target, cut, wv, hv, we, he, r;
    bit   need_geom;
    corner_px = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd7};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    calm = 1'b0;

    // 3x2 frame with power-on kernel: row zero, column zero, right edge, drain
    set_geometry(3, 2);
    set_filter(-256, LAP4_EDGE, LAP4_MID, LAP4_EDGE);
    send_beat(MODE_DRAIN, 8'h5A);
    ignored_beats++;
    foreach (corner_px[i]) begin
      send_beat(MODE_PIXEL, corner_px[i]);
      beats_sent++;
    end
    send_beat(MODE_PIXEL, 8'hFF);
    ignored_beats++;
    repeat (3) begin
      send_beat(MODE_DRAIN, pix_t'($urandom));
      beats_sent++;
    end
    send_beat(MODE_DRAIN, 8'h00);
    ignored_beats++;

    // zero geometry acts as a single pixel; gain and coefficient extremes
    set_geometry(0, 0);
    set_filter(511, K_ALL_MIN, K_ALL_MIN, K_ALL_MIN);
    send_beat(MODE_PIXEL, 8'hFF);
    send_beat(MODE_DRAIN, 8'h00);
    set_filter(-512, LAP8_EDGE, LAP8_EDGE, LAP8_EDGE);
    send_beat(MODE_PIXEL, 8'h00);
    send_beat(MODE_DRAIN, 8'hFF);
    send_beat(MODE_PIXEL, 8'hFF);
    send_beat(MODE_DRAIN, 8'h00);
    beats_sent += 6;

    // geometry write in the middle of a frame restarts it
    set_geometry(2, 3);
    set_filter(256, K_ALL_MAX, K_ZERO, K_ALL_MAX);
    run_frame(2, 3, 3, 0);
    set_geometry(2, 2);
    run_frame(2, 2, -1, 3);

    // random frames, mostly small, some cut short
    target    = beats_sent + RANDOM_BEATS;
    need_geom = 1'b1;
    we        = 2;
    he        = 2;
    while (beats_sent < target) begin
      calm = ($urandom_range(0, 3) == 0);
      if (need_geom || $urandom_range(0, 1) != 0) begin
        r  = $urandom_range(0, 99);
        wv = (r < 5) ? 0 : (r < 75) ? $urandom_range(1, 8) :
             (r < 95) ? $urandom_range(9, 32) : $urandom_range(33, 80);
        if (wv > 32) hv = $urandom_range(1, 3);
        else if ($urandom_range(0, 19) == 0) hv = 0;
        else if ($urandom_range(0, 9) == 0) hv = $urandom_range(6, 12);
        else hv = $urandom_range(1, 5);
        set_geometry(wv, hv);
        we = clamp_dim(wv, MAX_WIDTH);
        he = clamp_dim(hv, MAX_HEIGHT);
      end
      if ($urandom_range(0, 99) < 40) random_filter();
      cut = ($urandom_range(0, 99) < 8) ? int'($urandom_range(0, we * he - 1)) : -1;
      need_geom = (cut >= 0);
      run_frame(we, he, cut, $urandom_range(0, 3));
      settle();
    end

    // oversize height register clamps: start of a tall narrow frame, cut short
    calm = 1'b1;
    set_geometry(5, 8191);
    random_filter();
    run_frame(5, MAX_HEIGHT, 40, 3);

    settle();
    $display("summary: %0d pixel and drain beats, %0d ignored beats, %0d results, %0d frames",
             beats_sent, ignored_beats, results, frames);
    $display("summary: widths 1..80, heights 1..12, oversize height, gain/kernel extremes, %s",
             "random stalls");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/lsh3_pkg.sv
src/lsh3_ram.sv
src/laplacian_sharpen_3x3.sv
src/lsh3_chk.sv
verif/sharpen_checker.sv
verif/tb_top.sv
